// ----- hdl/stpt_pkg.sv -----
// ----------------------------------------------------------------------------
// stpt_pkg
// Sizes, derived widths and shared types of the sieve-backed primality tester.
// ----------------------------------------------------------------------------
package stpt_pkg;

    localparam int SIEVE_LIMIT = 16384;
    localparam int VALUE_BITS  = 28;
    localparam int PRIME_SLOTS = 1900;

    localparam int PRIME_BITS  = $clog2(SIEVE_LIMIT);
    localparam int SLOT_BITS   = $clog2(PRIME_SLOTS);
    localparam int COUNT_BITS  = $clog2(PRIME_SLOTS + 1);
    localparam int MULT_BITS   = PRIME_BITS + 1;
    localparam int SQ_BITS     = 2 * PRIME_BITS;
    localparam int CMP_BITS    = (SQ_BITS > VALUE_BITS) ? SQ_BITS : VALUE_BITS;

    // remainder unit: dividend bits retired per cycle
    localparam int STEP_BITS     = 4;
    localparam int DIV_STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS      = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    function automatic int f_ceil_sqrt(input int v);
        int r;
        r = 0;
        while (r * r < v) begin
            r++;
        end
        return r;
    endfunction

    // primes below this bound are the only ones whose multiples get marked
    localparam int SIEVE_ROOT = f_ceil_sqrt(SIEVE_LIMIT);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [PRIME_BITS-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic                  done;
        logic [PRIME_BITS-1:0] rem;
    } t_rem_rsp;

endpackage

// ----- hdl/stpt_ram.sv -----
// ----------------------------------------------------------------------------
// stpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/stpt_rem.sv -----
// ----------------------------------------------------------------------------
// stpt_rem
// Shared remainder unit: restoring division, STEP_BITS dividend bits a cycle.
// ----------------------------------------------------------------------------
module stpt_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stpt_pkg::t_rem_req i_req,
    output stpt_pkg::t_rem_rsp o_rsp
);

    logic                                  r_busy;
    logic                                  n_busy;
    logic                                  r_done;
    logic                                  n_done;
    logic [stpt_pkg::STEP_CNT_BITS-1:0]    r_cnt;
    logic [stpt_pkg::STEP_CNT_BITS-1:0]    n_cnt;
    logic [stpt_pkg::DIV_BITS-1:0]         r_sh;
    logic [stpt_pkg::DIV_BITS-1:0]         n_sh;
    logic [stpt_pkg::PRIME_BITS-1:0]       r_rem;
    logic [stpt_pkg::PRIME_BITS-1:0]       n_rem;
    logic [stpt_pkg::PRIME_BITS-1:0]       r_div;
    logic [stpt_pkg::PRIME_BITS-1:0]       n_div;
    logic [stpt_pkg::PRIME_BITS-1:0]       step_rem;
    logic [stpt_pkg::PRIME_BITS:0]         trial;

    // one step: STEP_BITS chained compare and subtract on narrow values
    always_comb begin
        step_rem = r_rem;
        trial    = '0;
        for (int j = 0; j < stpt_pkg::STEP_BITS; j++) begin
            trial = {step_rem, r_sh[stpt_pkg::DIV_BITS-1-j]};
            if (trial >= {1'b0, r_div}) begin
                step_rem = stpt_pkg::PRIME_BITS'(trial - {1'b0, r_div});
            end else begin
                step_rem = trial[stpt_pkg::PRIME_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_sh   = stpt_pkg::DIV_BITS'(i_req.dividend);
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_sh  = r_sh << stpt_pkg::STEP_BITS;
            n_rem = step_rem;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == stpt_pkg::STEP_CNT_BITS'(stpt_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hdl/sieve_trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// sieve_trial_division_prime_test
// Primality tester: sieve-built prime table, lookup for small numbers and
// trial division through a shared remainder unit for large ones.
// ----------------------------------------------------------------------------
// after reset: a clearing pass over the mark table, then the sieve, which marks every multiple
//   of each prime below SIEVE_ROOT; no word accepted until then
// per word: below 2 is flagged not prime directly, up to the largest stored prime by lookup,
//   otherwise by trial division by the stored primes in turn until one divides, its square
//   exceeds the word or the list runs out, with the remainder unit retiring 4 dividend bits a cycle
// one word at a time; the result sits in an output register
module sieve_trial_division_prime_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [27:0] candidate, rest zero
    input  logic [stpt_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] prime flag, rest zero
    output logic [stpt_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_SV_RD   = 4'd1;
    localparam logic [3:0] S_SV_CHK  = 4'd2;
    localparam logic [3:0] S_SV_MARK = 4'd3;
    localparam logic [3:0] S_IDLE    = 4'd4;
    localparam logic [3:0] S_LK      = 4'd5;
    localparam logic [3:0] S_TD_RD   = 4'd6;
    localparam logic [3:0] S_TD_LD   = 4'd7;
    localparam logic [3:0] S_TD_CMP  = 4'd8;
    localparam logic [3:0] S_TD_DIV  = 4'd9;
    localparam logic [3:0] S_RES     = 4'd10;

    localparam int PB = stpt_pkg::PRIME_BITS;
    localparam int CB = stpt_pkg::CMP_BITS;

    logic [3:0]                         r_state;
    logic [3:0]                         n_state;
    logic [PB-1:0]                      r_k;
    logic [PB-1:0]                      n_k;
    logic [stpt_pkg::MULT_BITS-1:0]     r_t;
    logic [stpt_pkg::MULT_BITS-1:0]     n_t;
    logic [stpt_pkg::COUNT_BITS-1:0]    r_count;
    logic [stpt_pkg::COUNT_BITS-1:0]    n_count;
    logic [PB-1:0]                      r_last;
    logic [PB-1:0]                      n_last;
    logic [stpt_pkg::VALUE_BITS-1:0]    r_n;
    logic [stpt_pkg::VALUE_BITS-1:0]    n_n;
    logic [stpt_pkg::SLOT_BITS-1:0]     r_idx;
    logic [stpt_pkg::SLOT_BITS-1:0]     n_idx;
    logic [PB-1:0]                      r_p;
    logic [PB-1:0]                      n_p;
    logic [stpt_pkg::SQ_BITS-1:0]       r_sq;
    logic [stpt_pkg::SQ_BITS-1:0]       n_sq;
    logic                               r_res;
    logic                               n_res;
    logic                               r_ovalid;
    logic                               n_ovalid;
    logic                               r_odata;
    logic                               n_odata;

    logic                               mark_we;
    logic [PB-1:0]                      mark_waddr;
    logic                               mark_wdata;
    logic [PB-1:0]                      mark_raddr;
    logic                               mark_rdata;
    logic                               list_we;
    logic [stpt_pkg::SLOT_BITS-1:0]     list_waddr;
    logic [PB-1:0]                      list_rdata;

    logic                               accept;
    logic [stpt_pkg::VALUE_BITS-1:0]    cand;
    logic                               sq_over;
    logic                               k_last;
    stpt_pkg::t_rem_req                 rem_req;
    stpt_pkg::t_rem_rsp                 rem_rsp;

    assign cand    = stpt_pkg::VALUE_BITS'(i_s_axis_tdata);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign sq_over = CB'(r_sq) > CB'(r_n);
    assign k_last  = (r_k == PB'(stpt_pkg::SIEVE_LIMIT - 1));

    // composite marks, one bit per number below the sieve limit
    stpt_ram #(
        .WIDTH (1),
        .DEPTH (stpt_pkg::SIEVE_LIMIT)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    stpt_ram #(
        .WIDTH (PB),
        .DEPTH (stpt_pkg::PRIME_SLOTS)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (r_k),
        .i_raddr (r_idx),
        .o_rdata (list_rdata)
    );

    stpt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = r_k;
        mark_wdata = 1'b0;
        mark_raddr = r_k;
        list_we    = 1'b0;
        list_waddr = stpt_pkg::SLOT_BITS'(r_count);
        unique case (r_state)
            S_CLR: begin
                mark_we = 1'b1;
            end
            S_SV_CHK: begin
                list_we = !mark_rdata &&
                          (r_count < stpt_pkg::COUNT_BITS'(stpt_pkg::PRIME_SLOTS));
            end
            S_SV_MARK: begin
                mark_we    = r_t < stpt_pkg::MULT_BITS'(stpt_pkg::SIEVE_LIMIT);
                mark_waddr = PB'(r_t);
                mark_wdata = 1'b1;
            end
            S_IDLE: begin
                mark_raddr = PB'(cand);
            end
            default: begin
            end
        endcase
    end

    assign rem_req.start    = (r_state == S_TD_CMP) && !sq_over;
    assign rem_req.dividend = r_n;
    assign rem_req.divisor  = r_p;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_t      = r_t;
        n_count  = r_count;
        n_last   = r_last;
        n_n      = r_n;
        n_idx    = r_idx;
        n_p      = r_p;
        n_sq     = r_sq;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;
        unique case (r_state)
            S_CLR: begin
                if (k_last) begin
                    n_k     = PB'(2);
                    n_state = S_SV_RD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SV_RD: begin
                n_state = S_SV_CHK;
            end
            S_SV_CHK: begin
                if (!mark_rdata && r_k < PB'(stpt_pkg::SIEVE_ROOT)) begin
                    n_t     = {r_k, 1'b0};
                    n_state = S_SV_MARK;
                end else if (k_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SV_RD;
                end
                if (list_we) begin
                    n_count = r_count + 1'b1;
                    n_last  = r_k;
                end
            end
            S_SV_MARK: begin
                if (mark_we) begin
                    n_t = r_t + stpt_pkg::MULT_BITS'(r_k);
                end else if (k_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SV_RD;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_n   = cand;
                    n_idx = '0;
                    priority if (cand < stpt_pkg::VALUE_BITS'(2)) begin
                        n_res   = 1'b0;
                        n_state = S_RES;
                    end else if (CB'(cand) <= CB'(r_last)) begin
                        n_state = S_LK;
                    end else begin
                        n_state = S_TD_RD;
                    end
                end
            end
            S_LK: begin
                n_res   = !mark_rdata;
                n_state = S_RES;
            end
            S_TD_RD: begin
                n_state = S_TD_LD;
            end
            S_TD_LD: begin
                n_p     = list_rdata;
                n_sq    = stpt_pkg::SQ_BITS'(list_rdata) * stpt_pkg::SQ_BITS'(list_rdata);
                n_state = S_TD_CMP;
            end
            S_TD_CMP: begin
                if (sq_over) begin
                    n_res   = 1'b1;
                    n_state = S_RES;
                end else begin
                    n_state = S_TD_DIV;
                end
            end
            S_TD_DIV: begin
                if (rem_rsp.done) begin
                    priority if (rem_rsp.rem == '0) begin
                        n_res   = 1'b0;
                        n_state = S_RES;
                    end else if (stpt_pkg::COUNT_BITS'(r_idx) + 1'b1 == r_count) begin
                        n_res   = 1'b1;
                        n_state = S_RES;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_TD_RD;
                    end
                end
            end
            S_RES: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_k      <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_last  <= n_last;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_p     <= n_p;
        r_sq    <= n_sq;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = stpt_pkg::OUT_TDATA_BITS'(r_odata);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stpt_pkg::COUNT_BITS'(stpt_pkg::PRIME_SLOTS))
        else $error("prime count beyond table size");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TD_RD) |-> (stpt_pkg::COUNT_BITS'(r_idx) < r_count))
        else $error("trial division index past stored primes");

    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_rsp.done |-> (r_state == S_TD_DIV))
        else $error("remainder finished outside trial division");

    a_small_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_n < stpt_pkg::VALUE_BITS'(2)) |-> !r_res)
        else $error("zero or one flagged prime");

endmodule
